@@ rtl/nps_pkg.sv @@
`timescale 1ns / 1ps

package nps_pkg;

  // Default sizes of the point table and of one stored coordinate.
  localparam int MAX_POINTS_DEF = 256;
  localparam int COORD_BITS_DEF = 16;

  // Widths of the stream fields.
  localparam int INDEX_W  = 8;
  localparam int IN_CRD_W = 16;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;
  localparam int IN_DATA_W  = INDEX_W + 3 * IN_CRD_W;
  localparam int OUT_DATA_W = INDEX_W;

  // Command codes carried in the input tuser.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Status codes returned with each query result.
  localparam logic [STATUS_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_OTHER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

endpackage

@@ rtl/nps_ram.sv @@
`timescale 1ns / 1ps

module nps_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/nps_dist.sv @@
`timescale 1ns / 1ps

// Two-stage squared-distance unit: absolute differences, then squares.
// The three squares leave through registers; the caller adds them.
module nps_dist #(
  parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF,
  parameter int TAG_W      = 9
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [TAG_W-1:0]               in_tag,
  input  logic [3*COORD_BITS-1:0]        pt,
  input  logic [3*COORD_BITS-1:0]        qpt,
  output logic                           out_valid,
  output logic [TAG_W-1:0]               out_tag,
  output logic [3*(2*COORD_BITS+2)-1:0]  out_sq,
  output logic                           busy
);

  localparam int MW = COORD_BITS + 1;
  localparam int SW = 2 * MW;

  logic              a_v_r;
  logic [TAG_W-1:0]  a_tag_r;
  logic [MW-1:0]     a_mag_r [3];
  logic              b_v_r;
  logic [TAG_W-1:0]  b_tag_r;
  logic [SW-1:0]     b_sq_r [3];
  logic [MW-1:0]     mag_nxt [3];

  // Magnitude of each coordinate difference; it never exceeds 2^COORD_BITS.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [MW-1:0] d;
      d = $signed({pt[k*COORD_BITS+COORD_BITS-1], pt[k*COORD_BITS +: COORD_BITS]})
        - $signed({qpt[k*COORD_BITS+COORD_BITS-1], qpt[k*COORD_BITS +: COORD_BITS]});
      mag_nxt[k] = d[MW-1] ? MW'(~d + 1'b1) : MW'(d);
    end
  end

  // Valid bits of both stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk) begin
    a_tag_r <= in_tag;
    b_tag_r <= a_tag_r;
    for (int k = 0; k < 3; k++) begin
      a_mag_r[k] <= mag_nxt[k];
      b_sq_r[k]  <= a_mag_r[k] * a_mag_r[k];
    end
  end

  assign out_valid = b_v_r;
  assign out_tag   = b_tag_r;
  assign out_sq    = {b_sq_r[2], b_sq_r[1], b_sq_r[0]};
  assign busy      = a_v_r | b_v_r;

endmodule

@@ rtl/nearest_point_search.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Contents
// in_       in   tvalid/tready      tuser: command; tdata: index, x, y, z
// out_      out  tvalid/tready      tuser: status; tdata: closest index
// cfg_      in   wr_en              wr_data: point count
//
// A load writes the table directly; a query streams the active points out of
// the table RAM read port, one stored point a cycle, into the distance unit.
// Reset clears the sequencer, the output valid and the point count; the table
// itself holds no reset value. A stalled result waits in the output register
// and the next item is still taken; a finished query waits until it is free.
module nearest_point_search #(
  parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = nps_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: point_index[7:0], coord_x[23:8], coord_y[39:24], coord_z[55:40]
  input  logic [nps_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: command[0]
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata: closest_index[7:0]
  output logic [nps_pkg::OUT_DATA_W-1:0]     out_tdata,
  // tuser: status[1:0]
  output logic [nps_pkg::STATUS_W-1:0]       out_tuser,
  input  logic                               cfg_wr_en,
  input  logic [nps_pkg::COUNT_W-1:0]        cfg_wr_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int CMP_W = (CNT_W > nps_pkg::COUNT_W) ? CNT_W : nps_pkg::COUNT_W;
  localparam int PT_W  = 3 * COORD_BITS;
  localparam int SW    = 2 * COORD_BITS + 2;
  localparam int DW    = SW + 2;
  localparam int TAG_W = IDX_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QRD   = 3'd1;
  localparam logic [2:0] S_QCAP  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic [nps_pkg::COUNT_W-1:0]   count_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [IDX_W-1:0]              qidx_r;
  logic [CNT_W-1:0]              j_r;
  logic [PT_W-1:0]               qpt_r;
  logic                          s1_v_r;
  logic [TAG_W-1:0]              s1_tag_r;
  logic                          found_r;
  logic [IDX_W-1:0]              best_j_r;
  logic [DW-1:0]                 best_d_r;
  logic [nps_pkg::STATUS_W-1:0]  res_status_r;
  logic [nps_pkg::INDEX_W-1:0]   res_idx_r;
  logic                          out_v_r;
  logic [nps_pkg::STATUS_W-1:0]  out_status_r;
  logic [nps_pkg::INDEX_W-1:0]   out_idx_r;

  logic                          in_xfer;
  logic                          cmd;
  logic [nps_pkg::INDEX_W-1:0]   in_idx;
  logic [PT_W-1:0]               ld_pt;
  logic                          ld_ok;
  logic [CMP_W-1:0]              eff_cnt;
  logic                          q_range_bad;
  logic [IDX_W-1:0]              rd_addr;
  logic [PT_W-1:0]               rd_data;
  logic                          d_v;
  logic [TAG_W-1:0]              d_tag;
  logic [3*SW-1:0]               d_sq;
  logic                          d_busy;
  logic [DW-1:0]                 d_sum;
  logic                          out_free;

  // Field unpacking and coordinate wrapping to the stored width.
  assign cmd    = in_tuser;
  assign in_idx = in_tdata[nps_pkg::INDEX_W-1:0];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [nps_pkg::IN_CRD_W-1:0] c;
      c = $signed(in_tdata[nps_pkg::INDEX_W + k*nps_pkg::IN_CRD_W +: nps_pkg::IN_CRD_W]);
      ld_pt[k*COORD_BITS +: COORD_BITS] = COORD_BITS'(c);
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign out_free  = !out_v_r || out_tready;

  // Active count is the register clipped to the table size.
  always_comb begin
    logic [CMP_W-1:0] c_ext;
    logic [CMP_W-1:0] m_ext;
    c_ext = CMP_W'(count_r);
    m_ext = CMP_W'(MAX_POINTS);
    eff_cnt = (c_ext > m_ext) ? m_ext : c_ext;
  end
  assign q_range_bad = CMP_W'(in_idx) >= eff_cnt;
  assign ld_ok       = CMP_W'(in_idx) < CMP_W'(MAX_POINTS);

  // Point table.
  assign rd_addr = (state_r == S_QRD) ? qidx_r : j_r[IDX_W-1:0];

  nps_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (in_xfer && cmd == nps_pkg::CMD_LOAD && ld_ok),
    .wr_addr (IDX_W'(in_idx)),
    .wr_data (ld_pt),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared distance unit, fed one stored point per cycle.
  nps_dist #(
    .COORD_BITS (COORD_BITS),
    .TAG_W      (TAG_W)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_v_r),
    .in_tag    (s1_tag_r),
    .pt        (rd_data),
    .qpt       (qpt_r),
    .out_valid (d_v),
    .out_tag   (d_tag),
    .out_sq    (d_sq),
    .busy      (d_busy)
  );

  assign d_sum = DW'(d_sq[0 +: SW]) + DW'(d_sq[SW +: SW]) + DW'(d_sq[2*SW +: SW]);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && cmd == nps_pkg::CMD_QUERY) begin
          state_nxt = q_range_bad ? S_DONE : S_QRD;
        end
      end
      S_QRD:   state_nxt = S_QCAP;
      S_QCAP:  state_nxt = S_WALK;
      S_WALK: begin
        if (j_r == cnt_r - 1'b1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!s1_v_r && !d_busy && !d_v) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      s1_v_r  <= 1'b0;
      found_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      s1_v_r <= (state_r == S_WALK);
      if (state_r == S_QRD) begin
        found_r <= 1'b0;
      end else if (d_v && !d_tag[IDX_W] && (!found_r || d_sum < best_d_r)) begin
        found_r <= 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cnt_r  <= CNT_W'(eff_cnt);
      qidx_r <= IDX_W'(in_idx);
    end
    if (state_r == S_QCAP) begin
      qpt_r <= rd_data;
      j_r   <= '0;
    end else if (state_r == S_WALK) begin
      j_r <= j_r + 1'b1;
    end
    s1_tag_r <= {j_r[IDX_W-1:0] == qidx_r, j_r[IDX_W-1:0]};
    if (d_v && !d_tag[IDX_W] && (!found_r || d_sum < best_d_r)) begin
      best_j_r <= d_tag[IDX_W-1:0];
      best_d_r <= d_sum;
    end
    // Result staging.
    if (in_xfer) begin
      res_status_r <= nps_pkg::ST_RANGE;
      res_idx_r    <= '0;
    end else if (state_r == S_DRAIN) begin
      res_status_r <= found_r ? nps_pkg::ST_FOUND : nps_pkg::ST_NO_OTHER;
      res_idx_r    <= found_r ? nps_pkg::INDEX_W'(best_j_r) : '0;
    end
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_idx_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = out_idx_r;

  // During the walk the queried point never wins its own search.
  a_not_self: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK || state_r == S_DRAIN) && found_r |-> best_j_r != qidx_r)
    else $error("nearest point equals the queried point");

  // During the walk the winner lies inside the active range.
  a_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK || state_r == S_DRAIN) && found_r |-> CNT_W'(best_j_r) < cnt_r)
    else $error("nearest point beyond active count");

  // No new item enters while the distance pipeline still holds work.
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !s1_v_r && !d_busy && !d_v)
    else $error("input taken while search still in flight");

  // A query result is only presented after the sequencer finished.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside the done state");

endmodule
